FILE: hw/rtl/jcsc_pkg.sv
package jcsc_pkg;

  // Field widths
  localparam int CoefW  = 12;
  localparam int DiffW  = 13;
  localparam int SizeW  = 4;
  localparam int SymW   = 8;
  localparam int RunW   = 4;
  localparam int ZrlW   = 2;
  localparam int PosW   = 6;
  localparam int CompW  = 2;

  localparam int NumComponentsDefault = 3;
  localparam int QueueDepth           = 4;

  localparam logic [SymW-1:0] SymZrl  = 8'hF0;
  localparam logic [PosW-1:0] LastPos = 6'd63;
  localparam logic [PosW-1:0] DcPos   = 6'd0;

  // One classified request from the front to the back
  typedef struct packed {
    logic                    is_dc;
    logic signed [DiffW-1:0] value;
    logic [ZrlW-1:0]         zrl_count;
    logic [RunW-1:0]         run;
    logic                    eob;
  } cmd_t;

  typedef struct packed {
    logic valid;
    cmd_t cmd;
  } cmd_req_t;

  // Size category: index of the highest set bit plus one
  function automatic logic [SizeW-1:0] size_of(input logic [CoefW-1:0] mag);
    logic [SizeW-1:0] s;
    s = '0;
    for (int i = 0; i < CoefW; i++) begin
      if (mag[i]) s = SizeW'(i + 1);
    end
    return s;
  endfunction

endpackage

FILE: hw/rtl/jcsc_front.sv
module jcsc_front import jcsc_pkg::*; #(
  parameter int NUM_COMPONENTS = NumComponentsDefault
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    push,
  input  logic                    q_full,
  input  logic signed [CoefW-1:0] coefficient,
  input  logic [CompW-1:0]        component,
  output cmd_req_t                req
);

  localparam int IdxW = (NUM_COMPONENTS > 1) ? $clog2(NUM_COMPONENTS) : 1;

  logic [PosW-1:0]         position;
  logic [PosW-1:0]         zero_run;
  logic signed [CoefW-1:0] dc_predictor [NUM_COMPONENTS];

  logic             accept;
  logic [CompW-1:0] comp_sat;
  logic [IdxW-1:0]  comp_idx;
  logic             coef_zero;

  assign accept    = push && !q_full;
  assign coef_zero = (coefficient == '0);

  // Saturate the component to the last predictor
  always_comb begin
    if ({1'b0, component} >= (CompW + 1)'(NUM_COMPONENTS)) begin
      comp_sat = CompW'(NUM_COMPONENTS - 1);
    end else begin
      comp_sat = component;
    end
  end
  assign comp_idx = comp_sat[IdxW-1:0];

  // Classify the item into a request for the back
  always_comb begin
    req           = '0;
    req.cmd.value = DiffW'(coefficient);
    req.cmd.eob   = (position == LastPos);
    if (position == DcPos) begin
      req.valid        = accept;
      req.cmd.is_dc    = 1'b1;
      req.cmd.eob      = 1'b0;
      req.cmd.value    = DiffW'(coefficient) - DiffW'(dc_predictor[comp_idx]);
    end else if (coef_zero) begin
      req.valid = accept && (position == LastPos);
    end else begin
      req.valid         = accept;
      req.cmd.zrl_count = zero_run[PosW-1:RunW];
      req.cmd.run       = zero_run[RunW-1:0];
    end
  end

  // Advance position, zero run and predictors
  always_ff @(posedge clk) begin
    if (rst) begin
      position <= '0;
      zero_run <= '0;
      for (int i = 0; i < NUM_COMPONENTS; i++) dc_predictor[i] <= '0;
    end else if (accept) begin
      position <= position + 1'b1;
      if (position == DcPos) begin
        dc_predictor[comp_idx] <= coefficient;
        zero_run <= '0;
      end else if (coef_zero && position != LastPos) begin
        zero_run <= zero_run + 1'b1;
      end else begin
        zero_run <= '0;
      end
    end
  end

endmodule

FILE: hw/rtl/jcsc_queue.sv
module jcsc_queue import jcsc_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  cmd_req_t wr,
  input  logic     rd,
  output cmd_t     rd_cmd,
  output logic     q_empty,
  output logic     q_full
);

  localparam int PtrW = $clog2(QueueDepth);
  localparam int CntW = $clog2(QueueDepth + 1);

  cmd_t            slots [QueueDepth];
  logic [PtrW-1:0] wr_ptr;
  logic [PtrW-1:0] rd_ptr;
  logic [CntW-1:0] count;

  logic do_wr;
  logic do_rd;

  assign q_empty = (count == '0);
  assign q_full  = (count == CntW'(QueueDepth));
  assign do_wr   = wr.valid && !q_full;
  assign do_rd   = rd && !q_empty;
  assign rd_cmd  = slots[rd_ptr];

  // Store requests
  always_ff @(posedge clk) begin
    if (do_wr) slots[wr_ptr] <= wr.cmd;
  end

  // Advance pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= (wr_ptr == PtrW'(QueueDepth - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_rd) begin
        rd_ptr <= (rd_ptr == PtrW'(QueueDepth - 1)) ? '0 : rd_ptr + 1'b1;
      end
      count <= count + CntW'(do_wr) - CntW'(do_rd);
    end
  end

endmodule

FILE: hw/rtl/jcsc_back.sv
module jcsc_back import jcsc_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  cmd_t             cmd,
  input  logic             q_empty,
  output logic             q_rd,
  input  logic             pop,
  output logic             empty,
  output logic             is_dc,
  output logic [SymW-1:0]  symbol,
  output logic [CoefW-1:0] amplitude_bits,
  output logic [SizeW-1:0] amplitude_length,
  output logic             end_of_block,
  output logic             last_of_item
);

  logic            out_valid;
  logic [ZrlW-1:0] zrl_done;

  logic             step;
  logic             emit_zrl;
  logic [CoefW-1:0] mag;
  logic [SizeW-1:0] size;
  logic [DiffW-1:0] val_m1;
  logic [CoefW-1:0] amp_mask;
  logic [CoefW-1:0] amp;
  logic [SymW-1:0]  sym_final;

  assign empty    = !out_valid;
  assign step     = !q_empty && (!out_valid || pop);
  assign emit_zrl = (zrl_done != cmd.zrl_count);
  assign q_rd     = step && !emit_zrl;

  // Size and amplitude code of the request value
  always_comb begin
    mag      = cmd.value[DiffW-1] ? CoefW'(-cmd.value) : cmd.value[CoefW-1:0];
    size     = size_of(mag);
    val_m1   = cmd.value - 1'b1;
    amp_mask = CoefW'((DiffW'(1) << size) - 1'b1);
    amp      = cmd.value[DiffW-1] ? (val_m1[CoefW-1:0] & amp_mask) : cmd.value[CoefW-1:0];
    if (cmd.is_dc) begin
      sym_final = SymW'(size);
    end else begin
      sym_final = {cmd.run, size};
    end
  end

  // Emit ZRL symbols first, then the request's own symbol
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      zrl_done  <= '0;
    end else begin
      if (step) begin
        out_valid <= 1'b1;
        zrl_done  <= emit_zrl ? zrl_done + 1'b1 : '0;
      end else if (pop) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Hold result payload
  always_ff @(posedge clk) begin
    if (step) begin
      if (emit_zrl) begin
        is_dc            <= 1'b0;
        symbol           <= SymZrl;
        amplitude_bits   <= '0;
        amplitude_length <= '0;
        end_of_block     <= 1'b0;
        last_of_item     <= 1'b0;
      end else begin
        is_dc            <= cmd.is_dc;
        symbol           <= sym_final;
        amplitude_bits   <= amp;
        amplitude_length <= size;
        end_of_block     <= cmd.eob;
        last_of_item     <= 1'b1;
      end
    end
  end

endmodule

FILE: hw/rtl/jpeg_coefficient_symbol_coder_core.sv
// JPEG baseline coefficient symbol coder: DC difference coding and AC
// run-length coding of quantized coefficients in zigzag order.
// Input channel: push/full. One coefficient per request, 64 per block; the
// component is sampled on the first coefficient of each block.
// Result channel: empty/pop. Each result is one symbol with its amplitude
// bits and length; last_of_item marks the last result of an input request,
// end_of_block the last symbol of a block. Zero AC coefficients before the
// last position give no result.
// Path: an accepted request is written into a queue slot, then into the
// result register once the result side is free. Throughput: one request
// per cycle in while full is low, one result per cycle out while pop is
// high; a coefficient after a zero run of 16 or more yields one extra
// result per ZRL (up to three), and the request queue between the
// classifier and the symbol emitter soaks these up. full rises when that
// queue holds QueueDepth requests. Reset clears the block position, the
// zero run, all DC predictors, the queue and the result valid flag.
// When the receiver stalls, the result holds; the queue keeps taking
// requests until it fills, then full holds off the sender.
module jpeg_coefficient_symbol_coder_core import jcsc_pkg::*; #(
  parameter int NUM_COMPONENTS = NumComponentsDefault
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    push,
  output logic                    full,
  input  logic signed [CoefW-1:0] coefficient,
  input  logic [CompW-1:0]        component,
  output logic                    empty,
  input  logic                    pop,
  output logic                    is_dc,
  output logic [SymW-1:0]         symbol,
  output logic [CoefW-1:0]        amplitude_bits,
  output logic [SizeW-1:0]        amplitude_length,
  output logic                    end_of_block,
  output logic                    last_of_item
);

  cmd_req_t req;
  cmd_t     q_cmd;
  logic     q_empty;
  logic     q_full;
  logic     q_rd;

  assign full = q_full;

  jcsc_front #(
    .NUM_COMPONENTS(NUM_COMPONENTS)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .q_full     (q_full),
    .coefficient(coefficient),
    .component  (component),
    .req        (req)
  );

  jcsc_queue u_queue (
    .clk    (clk),
    .rst    (rst),
    .wr     (req),
    .rd     (q_rd),
    .rd_cmd (q_cmd),
    .q_empty(q_empty),
    .q_full (q_full)
  );

  jcsc_back u_back (
    .clk             (clk),
    .rst             (rst),
    .cmd             (q_cmd),
    .q_empty         (q_empty),
    .q_rd            (q_rd),
    .pop             (pop),
    .empty           (empty),
    .is_dc           (is_dc),
    .symbol          (symbol),
    .amplitude_bits  (amplitude_bits),
    .amplitude_length(amplitude_length),
    .end_of_block    (end_of_block),
    .last_of_item    (last_of_item)
  );

  // A block's last symbol always closes its request
  a_eob_last: assert property (@(posedge clk) disable iff (rst)
    !empty && end_of_block |-> last_of_item)
    else $error("end_of_block without last_of_item");

  // A DC symbol is a single result and never ends the block
  a_dc_single: assert property (@(posedge clk) disable iff (rst)
    !empty && is_dc |-> last_of_item && !end_of_block)
    else $error("bad DC result flags");

  // A ZRL is always followed by more results of the same request
  a_zrl_not_last: assert property (@(posedge clk) disable iff (rst)
    !empty && !is_dc && symbol == SymZrl && amplitude_length == '0 |->
      !last_of_item && !end_of_block)
    else $error("ZRL marked as last result");

endmodule

FILE: tb/sv/jcsc_symbol_checker.sv
module jcsc_symbol_checker import jcsc_pkg::*; #(
  parameter int NUM_COMPONENTS = NumComponentsDefault
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    push,
  input  logic                    full,
  input  logic signed [CoefW-1:0] coefficient,
  input  logic [CompW-1:0]        component,
  input  logic                    empty,
  input  logic                    pop,
  input  logic                    is_dc,
  input  logic [SymW-1:0]         symbol,
  input  logic [CoefW-1:0]        amplitude_bits,
  input  logic [SizeW-1:0]        amplitude_length,
  input  logic                    end_of_block,
  input  logic                    last_of_item,
  output int                      pending,
  output int                      mismatches
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [SymW-1:0] SymEob    = 8'h00;
  localparam int              ZrlRun    = 16;
  localparam int              MaxZrl    = 3;
  localparam int              MaxBurst  = 4;

  typedef struct packed {
    logic              is_dc;
    logic [SymW-1:0]   symbol;
    logic [CoefW-1:0]  amp_bits;
    logic [SizeW-1:0]  amp_len;
    logic              eob;
    logic              last;
  } coded_symbol_t;

  coded_symbol_t           coded_symbols [$];
  coded_symbol_t           oldest;
  logic [PosW-1:0]         zz_pos;
  int                      run_len;
  logic signed [CoefW-1:0] dc_pred [NUM_COMPONENTS];

  // Size category: bit length of the magnitude
  function automatic int category(input int v);
    int m;
    int s;
    m = (v < 0) ? -v : v;
    s = 0;
    while (m != 0) begin
      s++;
      m = m >> 1;
    end
    return s;
  endfunction

  // Amplitude code: one's complement style for negative values
  function automatic logic [CoefW-1:0] amp_code(input int v, input int s);
    int a;
    a = (v >= 0) ? v : ((1 << s) - 1 + v);
    return a[CoefW-1:0];
  endfunction

  function automatic coded_symbol_t make_symbol(input logic dc, input logic [SymW-1:0] sym,
                                                input logic [CoefW-1:0] amp, input int len,
                                                input logic eob);
    coded_symbol_t r;
    r.is_dc    = dc;
    r.symbol   = sym;
    r.amp_bits = amp;
    r.amp_len  = len[SizeW-1:0];
    r.eob      = eob;
    r.last     = 1'b0;
    return r;
  endfunction

  // Advance the block state by one coefficient and queue the symbols it yields
  task automatic code_coefficient(input logic signed [CoefW-1:0] coef,
                                  input logic [CompW-1:0] comp);
    coded_symbol_t burst [MaxBurst];
    coded_symbol_t one;
    int            n;
    int            c;
    int            d;
    int            s;
    int            sel;
    logic [SymW-1:0] rs;
    n = 0;
    c = coef;
    if (zz_pos == DcPos) begin
      sel = comp;
      if (sel >= NUM_COMPONENTS) sel = NUM_COMPONENTS - 1;
      d = c - int'(dc_pred[sel]);
      dc_pred[sel] = coef;
      s = category(d);
      burst[n] = make_symbol(1'b1, SymW'(s), amp_code(d, s), s, 1'b0);
      n++;
      run_len = 0;
    end else if (c == 0) begin
      run_len = (run_len + 1) % 64;
      if (zz_pos == LastPos) begin
        burst[n] = make_symbol(1'b0, SymEob, '0, 0, 1'b1);
        n++;
        run_len = 0;
      end
    end else begin
      s = category(c);
      // emit one ZRL per full run of sixteen zeros
      while (run_len >= ZrlRun && n < MaxZrl) begin
        burst[n] = make_symbol(1'b0, SymZrl, '0, 0, 1'b0);
        n++;
        run_len -= ZrlRun;
      end
      rs = {run_len[3:0], s[3:0]};
      burst[n] = make_symbol(1'b0, rs, amp_code(c, s), s, zz_pos == LastPos);
      n++;
      run_len = 0;
    end
    for (int i = 0; i < n; i++) begin
      one = burst[i];
      one.last = (i == n - 1);
      coded_symbols.push_back(one);
    end
    zz_pos = zz_pos + 1'b1;
  endtask

  task automatic check_field(input string field, input int want, input int got);
    if (want != got) begin
      mismatches++;
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, field, want, got);
    end
  endtask

  // Predict on each accepted request, compare each accepted result
  always @(posedge clk) begin
    if (rst) begin
      zz_pos  = '0;
      run_len = 0;
      for (int i = 0; i < NUM_COMPONENTS; i++) dc_pred[i] = '0;
      coded_symbols.delete();
      pending    = 0;
      mismatches = 0;
    end else begin
      if (push && !full) code_coefficient(coefficient, component);
      if (pop && !empty) begin
        if (coded_symbols.size() == 0) begin
          mismatches++;
          $display("%0t: result with none expected, got symbol %0h amplitude %0h",
                   $time, symbol, amplitude_bits);
        end else begin
          oldest = coded_symbols.pop_front();
          check_field("is_dc", oldest.is_dc, is_dc);
          check_field("symbol", oldest.symbol, symbol);
          check_field("amplitude_bits", oldest.amp_bits, amplitude_bits);
          check_field("amplitude_length", oldest.amp_len, amplitude_length);
          check_field("end_of_block", oldest.eob, end_of_block);
          check_field("last_of_item", oldest.last, last_of_item);
        end
      end
      pending = coded_symbols.size();
    end
  end

endmodule

FILE: tb/sv/tb_jpeg_coefficient_symbol_coder_core.sv
module tb_jpeg_coefficient_symbol_coder_core import jcsc_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic signed [CoefW-1:0] CoefMin = 12'sh800;
  localparam logic signed [CoefW-1:0] CoefMax = 12'sh7FF;
  localparam int BlockLen      = 64;
  localparam int NumBlocks     = 7;
  localparam int DirectedItems = 25;
  localparam int PressureBlock = 4;
  localparam int HoldCycles    = 48;

  typedef enum int {StyleDense, StyleSparse, StyleTail, StyleEmpty} block_style_t;

  logic                    clk;
  logic                    rst;
  logic                    push;
  logic                    full;
  logic signed [CoefW-1:0] coefficient;
  logic [CompW-1:0]        component;
  logic                    empty;
  logic                    pop;
  logic                    is_dc;
  logic [SymW-1:0]         symbol;
  logic [CoefW-1:0]        amplitude_bits;
  logic [SizeW-1:0]        amplitude_length;
  logic                    end_of_block;
  logic                    last_of_item;
  int                      pending;
  int                      mismatches;

  int   tx_idle_pct;
  int   rx_stall_pct;
  logic hold_off;
  event hold_start;

  jpeg_coefficient_symbol_coder_core uut (
    .clk              (clk),
    .rst              (rst),
    .push             (push),
    .full             (full),
    .coefficient      (coefficient),
    .component        (component),
    .empty            (empty),
    .pop              (pop),
    .is_dc            (is_dc),
    .symbol           (symbol),
    .amplitude_bits   (amplitude_bits),
    .amplitude_length (amplitude_length),
    .end_of_block     (end_of_block),
    .last_of_item     (last_of_item)
  );

  jcsc_symbol_checker checker_i (
    .clk              (clk),
    .rst              (rst),
    .push             (push),
    .full             (full),
    .coefficient      (coefficient),
    .component        (component),
    .empty            (empty),
    .pop              (pop),
    .is_dc            (is_dc),
    .symbol           (symbol),
    .amplitude_bits   (amplitude_bits),
    .amplitude_length (amplitude_length),
    .end_of_block     (end_of_block),
    .last_of_item     (last_of_item),
    .pending          (pending),
    .mismatches       (mismatches)
  );

  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  // Nonzero value of random size class, or sometimes raw bits over the full range, zero included
  function automatic logic signed [CoefW-1:0] random_coef();
    int s;
    int m;
    if ($urandom_range(3) == 0) return CoefW'($urandom_range(4095));
    s = $urandom_range(12, 1);
    if (s == 12) return CoefMin;
    m = $urandom_range((1 << s) - 1, 1 << (s - 1));
    return CoefW'($urandom_range(1) ? -m : m);
  endfunction

  function automatic logic signed [CoefW-1:0] ac_coef(input block_style_t style, input int pos);
    case (style)
      StyleDense:  return ($urandom_range(99) < 25) ? '0 : random_coef();
      StyleSparse: return ($urandom_range(99) < 92) ? '0 : random_coef();
      StyleTail:   return (pos < BlockLen - 1) ? '0 : random_coef();
      default:     return '0;
    endcase
  endfunction

  // Offer one request and hold it until the block takes it
  task automatic send_coef(input logic signed [CoefW-1:0] coef, input logic [CompW-1:0] comp);
    while ($urandom_range(99) < tx_idle_pct) begin
      push = 1'b0;
      @(negedge clk);
    end
    push        = 1'b1;
    coefficient = coef;
    component   = comp;
    @(posedge clk);
    while (full) @(posedge clk);
    @(negedge clk);
  endtask

  // Receiver: random stalls plus the long hold-off
  initial begin
    pop = 1'b0;
    forever begin
      @(negedge clk);
      pop = !hold_off && ($urandom_range(99) >= rx_stall_pct);
    end
  end

  // Hold off the receiver for a long stretch so the block fills and stalls input
  initial begin
    hold_off = 1'b0;
    forever begin
      @(hold_start);
      hold_off = 1'b1;
      repeat (HoldCycles) @(negedge clk);
      hold_off = 1'b0;
    end
  end

  initial begin
    #2000000;
    $display("Verification failed");
    $finish;
  end

  initial begin
    block_style_t            style;
    logic signed [CoefW-1:0] dc;
    logic [CompW-1:0]        comp;
    int                      first;
    rst          = 1'b1;
    push         = 1'b0;
    coefficient  = '0;
    component    = '0;
    tx_idle_pct  = 0;
    rx_stall_pct = 0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed opening: field extremes, single ZRL, small runs
    send_coef(CoefMax, 2'd0);
    send_coef(CoefMin, 2'd0);
    send_coef(CoefMax, 2'd0);
    send_coef(12'sd1, 2'd0);
    send_coef(-12'sd1, 2'd0);
    repeat (16) send_coef('0, 2'd0);
    send_coef(-12'sd3, 2'd0);
    send_coef('0, 2'd0);
    send_coef(12'sd5, 2'd0);
    send_coef(12'sd1024, 2'd0);

    // Whole blocks with random content; the first starts mid-block
    for (int blk = 0; blk < NumBlocks; blk++) begin
      case (blk % 4)
        0: begin tx_idle_pct = 0;  rx_stall_pct = 0;  end
        1: begin tx_idle_pct = 53; rx_stall_pct = 0;  end
        2: begin tx_idle_pct = 0;  rx_stall_pct = 53; end
        default: begin tx_idle_pct = 24; rx_stall_pct = 24; end
      endcase
      if (blk == PressureBlock) -> hold_start;
      style = block_style_t'(blk % 4);
      first = (blk == 0) ? DirectedItems : 0;
      // DC extremes: full negative and positive swings, saturated component, zero difference
      case (blk)
        1: begin dc = CoefMin; comp = 2'd3; end
        2: begin dc = CoefMin; comp = 2'd0; end
        3: begin dc = CoefMax; comp = 2'd2; end
        4: begin dc = CoefMax; comp = 2'd3; end
        default: begin
          dc   = CoefW'($urandom_range(4095));
          comp = CompW'($urandom_range(3));
        end
      endcase
      for (int pos = first; pos < BlockLen; pos++) begin
        if (pos == 0) send_coef(dc, comp);
        else send_coef(ac_coef(style, pos), CompW'($urandom_range(3)));
      end
    end

    // Drain
    push         = 1'b0;
    tx_idle_pct  = 0;
    rx_stall_pct = 0;
    while (pending != 0) @(negedge clk);
    repeat (8) @(negedge clk);
    if (mismatches == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
